>>> design/tcd_pkg.sv
// shared types and constants for the thermostat with compressor delay
`default_nettype none

package tcd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TEMP_W   = 22;
    localparam int unsigned TARGET_W = 12;
    localparam int unsigned BAND_W   = 10;
    localparam int unsigned DELAY_W  = 8;
    localparam int unsigned IDLE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    typedef logic [BYTE_W-1:0]          byte_t;
    typedef logic signed [TEMP_W-1:0]   temp_t;
    typedef logic [TARGET_W-1:0]        target_t;
    typedef logic [BAND_W-1:0]          band_t;
    typedef logic [DELAY_W-1:0]         delay_t;
    typedef logic [IDLE_W-1:0]          idle_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    localparam cfg_idx_t REG_TARGET_TEMP     = 2'd0;
    localparam cfg_idx_t REG_HYSTERESIS_BAND = 2'd1;
    localparam cfg_idx_t REG_MIN_OFF_TICKS   = 2'd2;

    localparam target_t TARGET_RESET = 12'd1800;
    localparam band_t   BAND_RESET   = 10'd100;
    localparam delay_t  MIN_OFF_RESET = 8'd60;
    localparam idle_t   IDLE_MAX     = 16'hffff;

    localparam temp_t CENTI_PER_DEG = 22'sd100;
    localparam temp_t FRAC_OFFSET   = 22'sd25;

endpackage

`default_nettype wire

>>> design/tcd_if.sv
// channel interfaces: sensor sample, thermostat result, configuration write
`default_nettype none

interface tcd_in_if;
    logic           valid;
    logic           ready;
    tcd_pkg::byte_t reading_low;
    tcd_pkg::byte_t reading_high;
    tcd_pkg::byte_t count_remain;
    logic           sensor_absent;

    modport source (output valid, output reading_low, output reading_high,
                    output count_remain, output sensor_absent, input ready);
    modport sink   (input valid, input reading_low, input reading_high,
                    input count_remain, input sensor_absent, output ready);
endinterface

interface tcd_out_if;
    logic            valid;
    logic            ready;
    tcd_pkg::temp_t  temp_centi;
    logic            cool_demand;
    logic            relay_on;
    tcd_pkg::delay_t delay_left;

    modport source (output valid, output temp_centi, output cool_demand,
                    output relay_on, output delay_left, input ready);
    modport sink   (input valid, input temp_centi, input cool_demand,
                    input relay_on, input delay_left, output ready);
endinterface

interface tcd_cfg_if;
    logic               valid;
    logic               ready;
    tcd_pkg::cfg_idx_t  index;
    tcd_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/thermostat_with_compressor_delay_unit.sv
// thermostat top level: temperature conversion, hysteresis and restart delay
//
//  channel  dir  beat contents
//  sample   in   reading_low, reading_high, count_remain, sensor_absent
//  result   out  temp_centi, cool_demand, relay_on, delay_left
//  cfg      in   index, data (target_temp, hysteresis_band, min_off_ticks)
//
//  one beat per cycle sustained while result is ready; a beat waits in the input register
//  and is then registered onto result
//  compressor state and idle counter update as a beat moves to the result register
//  a stalled result holds; one more sample waits in the input register
//  rst_n clears state, registers return to 1800 / 100 / 60; cfg always ready
`default_nettype none

module thermostat_with_compressor_delay_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    tcd_in_if.sink    sample,
    tcd_out_if.source result,
    tcd_cfg_if.sink   cfg
);
    import tcd_pkg::*;

    target_t target_reg;
    band_t   band_reg;
    delay_t  min_off_reg;

    logic    in_valid_reg;
    byte_t   low_reg;
    byte_t   high_reg;
    byte_t   remain_reg;
    logic    absent_reg;

    logic    out_valid_reg;
    temp_t   temp_reg;
    logic    demand_reg;
    logic    relay_reg;
    delay_t  left_reg;

    logic    running_reg;
    logic    running_next;
    idle_t   idle_reg;
    idle_t   idle_next;

    logic    accept_in;
    logic    advance;
    temp_t   temp_now;
    logic signed [13:0] thr;
    logic    demand;
    logic    idle_lt;
    logic    idle_gt;
    delay_t  left;

    tcd_temp_calc u_temp_calc (
        .reading_low  (low_reg),
        .reading_high (high_reg),
        .count_remain (remain_reg),
        .temp_centi   (temp_now)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign accept_in    = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.temp_centi  = temp_reg;
    assign result.cool_demand = demand_reg;
    assign result.relay_on    = relay_reg;
    assign result.delay_left  = left_reg;

    // threshold uses running state from before this tick
    assign thr    = running_reg ? ($signed({2'b00, target_reg}) - $signed({4'b0000, band_reg}))
                                : ($signed({2'b00, target_reg}) + $signed({4'b0000, band_reg}));
    assign demand = temp_now > TEMP_W'(thr);

    assign idle_lt = idle_reg < IDLE_W'(min_off_reg);
    assign idle_gt = idle_reg > IDLE_W'(min_off_reg);
    assign left    = (demand && idle_lt) ? (min_off_reg - idle_reg[DELAY_W-1:0]) : '0;

    always_comb
    begin
        running_next = demand && !absent_reg && (running_reg || idle_gt);
        if (running_next)
        begin
            idle_next = '0;
        end
        else if (idle_reg != IDLE_MAX)
        begin
            idle_next = idle_reg + 1'b1;
        end
        else
        begin
            idle_next = idle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            band_reg      <= BAND_RESET;
            min_off_reg   <= MIN_OFF_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            idle_reg      <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TARGET_TEMP:     target_reg  <= cfg.data[TARGET_W-1:0];
                    REG_HYSTERESIS_BAND: band_reg    <= cfg.data[BAND_W-1:0];
                    REG_MIN_OFF_TICKS:   min_off_reg <= cfg.data[DELAY_W-1:0];
                    default:             ;
                endcase
            end
            if (accept_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                idle_reg      <= idle_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            low_reg    <= sample.reading_low;
            high_reg   <= sample.reading_high;
            remain_reg <= sample.count_remain;
            absent_reg <= sample.sensor_absent;
        end
        if (advance)
        begin
            temp_reg   <= temp_now;
            demand_reg <= demand;
            relay_reg  <= running_next;
            left_reg   <= left;
        end
    end

`ifndef SYNTHESIS
    a_relay_needs_demand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && relay_reg |-> demand_reg)
        else $error("relay on without demand");

    a_delay_needs_demand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (left_reg != '0) |-> demand_reg)
        else $error("delay reported without demand");

    a_running_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (idle_reg == '0))
        else $error("idle counter nonzero while running");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("waiting sample dropped");

    a_relay_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (relay_reg == running_reg))
        else $error("relay output differs from compressor state");
`endif

endmodule

`default_nettype wire

>>> design/tcd_temp_calc.sv
// raw sensor bytes to temperature in hundredths of a degree
`default_nettype none

module tcd_temp_calc (
    input  wire tcd_pkg::byte_t reading_low,
    input  wire tcd_pkg::byte_t reading_high,
    input  wire tcd_pkg::byte_t count_remain,
    output tcd_pkg::temp_t temp_centi
);
    import tcd_pkg::*;

    logic [15:0]        raw;
    logic signed [14:0] whole;
    temp_t              whole_ext;
    temp_t              scaled;
    logic [14:0]        rem_scaled;
    logic signed [16:0] num;
    logic signed [16:0] num_adj;
    logic signed [12:0] frac;

    assign raw        = {reading_high, reading_low};
    // floor of half the signed reading
    assign whole      = $signed(raw[15:1]);
    assign whole_ext  = TEMP_W'(whole);
    assign scaled     = whole_ext * CENTI_PER_DEG;

    assign rem_scaled = 15'(count_remain) * 15'd100;
    assign num        = 17'sd1600 - $signed({2'b00, rem_scaled});
    // divide by sixteen, truncating toward zero
    assign num_adj    = num + (num[16] ? 17'sd15 : 17'sd0);
    assign frac       = num_adj[16:4];

    assign temp_centi = scaled + TEMP_W'(frac) - FRAC_OFFSET;

endmodule

`default_nettype wire
